[hw/rtl/bppc_pkg.sv]
`timescale 1ns / 1ps

package bppc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int CMP_W      = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int TAP_BITS   = 8;

  localparam logic [TAP_BITS-1:0] TAP_MAX = {TAP_BITS{1'b1}};

  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET    = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] DOUBLE_WINDOW_RESET = CFG_BITS'(300);

  localparam logic REG_LONG_PRESS    = 1'b0;
  localparam logic REG_DOUBLE_WINDOW = 1'b1;

  typedef logic [1:0] tap_event_t;
  localparam tap_event_t EV_NONE   = 2'd0;
  localparam tap_event_t EV_SINGLE = 2'd1;
  localparam tap_event_t EV_DOUBLE = 2'd2;

  typedef logic [TIMER_BITS-1:0] timer_t;

endpackage

[hw/rtl/button_press_pattern_classifier_top.sv]
`timescale 1ns / 1ps

// Button press pattern classifier.
// Input channel (in_valid/in_ready, pin_level): one transaction per tick,
// carrying the sampled active-low button level.
// Output channel (out_valid/out_ready, long_press, tap_event): exactly one
// transaction per input transaction, in order. tap_event is 0 none,
// 1 single press, 2 double press; long_press marks an expired hold.
// Config port (APB style): long_press_ticks at 0x0, double_window_ticks at
// 0x4, 16 bits each, readable; write only while the block is idle.
// Output: the result is registered and valid in the cycle after the input is accepted.
// Throughput: one transaction per cycle while out_ready is high; all
// classification is one level of counter and compare logic between the state
// registers and the output register.
// Stall: when the receiver holds out_ready low, the result register keeps
// its transaction and in_ready drops until it is taken.
// Reset (rst, synchronous): timers stopped, tap count zero, button seen as
// released, thresholds back to 1000 and 300 ticks, output empty.
module button_press_pattern_classifier_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bppc_pkg::ADDR_W-1:0] paddr,
  input  logic [bppc_pkg::DATA_W-1:0] pwdata,
  output logic [bppc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        pin_level,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        long_press,
  output logic [1:0]                  tap_event
);
  import bppc_pkg::*;

  logic [CFG_BITS-1:0] long_press_ticks;
  logic [CFG_BITS-1:0] double_window_ticks;

  logic                last_level;
  logic                held;
  timer_t              hold_counter;
  logic                hold_timer_running;
  timer_t              window_counter;
  logic                window_running;
  logic [TAP_BITS-1:0] tap_count;

  logic                last_level_next;
  logic                held_next;
  timer_t              hold_counter_next;
  logic                hold_timer_running_next;
  timer_t              window_counter_next;
  logic                window_running_next;
  logic [TAP_BITS-1:0] tap_count_next;
  logic                long_press_next;
  tap_event_t          tap_event_next;

  timer_t              win_inc;
  timer_t              hold_inc;
  logic                win_exp;
  logic                hold_exp;
  logic [TAP_BITS-1:0] tap_after_win;
  logic [TAP_BITS-1:0] tap_after_hold;
  logic                fall;
  logic                rise;
  logic                accept;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    case (paddr[2])
      REG_LONG_PRESS:    prdata = DATA_W'(long_press_ticks);
      REG_DOUBLE_WINDOW: prdata = DATA_W'(double_window_ticks);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks    <= LONG_PRESS_RESET;
      double_window_ticks <= DOUBLE_WINDOW_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_LONG_PRESS) begin
        long_press_ticks <= pwdata[CFG_BITS-1:0];
      end else begin
        double_window_ticks <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  always_comb begin
    win_inc  = (window_counter == {TIMER_BITS{1'b1}}) ? window_counter
                                                      : window_counter + 1'b1;
    hold_inc = (hold_counter == {TIMER_BITS{1'b1}}) ? hold_counter
                                                    : hold_counter + 1'b1;

    // window timer first
    window_counter_next = window_running ? win_inc : window_counter;
    win_exp = window_running &&
              (CMP_W'(win_inc) >= CMP_W'(double_window_ticks));
    tap_event_next = EV_NONE;
    if (win_exp) begin
      if (tap_count >= TAP_BITS'(2)) begin
        tap_event_next = EV_DOUBLE;
      end else if (tap_count == TAP_BITS'(1)) begin
        tap_event_next = EV_SINGLE;
      end
    end
    tap_after_win       = win_exp ? '0 : tap_count;
    window_running_next = window_running && !win_exp;

    // then the hold timer
    hold_counter_next = hold_timer_running ? hold_inc : hold_counter;
    hold_exp = hold_timer_running &&
               (CMP_W'(hold_inc) >= CMP_W'(long_press_ticks));
    long_press_next         = hold_exp && held;
    tap_after_hold          = hold_exp ? '0 : tap_after_win;
    hold_timer_running_next = hold_timer_running && !hold_exp;
    tap_count_next          = tap_after_hold;
    held_next               = held;

    // then the pin edge
    fall = last_level && !pin_level;
    rise = !last_level && pin_level && held;
    if (fall) begin
      held_next               = 1'b1;
      hold_counter_next       = '0;
      hold_timer_running_next = 1'b1;
    end else if (rise) begin
      held_next               = 1'b0;
      hold_timer_running_next = 1'b0;
      if (CMP_W'(hold_counter_next) < CMP_W'(long_press_ticks)) begin
        if (tap_after_hold != TAP_MAX) begin
          tap_count_next = tap_after_hold + 1'b1;
        end
        window_counter_next = '0;
        window_running_next = 1'b1;
      end
    end
    last_level_next = pin_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level         <= 1'b1;
      held               <= 1'b0;
      hold_counter       <= '0;
      hold_timer_running <= 1'b0;
      window_counter     <= '0;
      window_running     <= 1'b0;
      tap_count          <= '0;
    end else if (accept) begin
      last_level         <= last_level_next;
      held               <= held_next;
      hold_counter       <= hold_counter_next;
      hold_timer_running <= hold_timer_running_next;
      window_counter     <= window_counter_next;
      window_running     <= window_running_next;
      tap_count          <= tap_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      long_press <= long_press_next;
      tap_event  <= tap_event_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_low: assert property (@(posedge clk) disable iff (rst)
    held |-> !last_level)
    else $error("held set while last level is high");

  a_hold_needs_held: assert property (@(posedge clk) disable iff (rst)
    hold_timer_running |-> held)
    else $error("hold timer running without a press");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted transaction produced no result");
`endif

endmodule
